/* rtl/lfpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpf_pkg
// Shared constants, codes and types of the length-framed packet FIFO.
// ----------------------------------------------------------------------------
package lfpf_pkg;

  localparam int DATA_DEPTH   = 1024;
  localparam int RECORD_DEPTH = 16;
  localparam int MAX_PACKET   = 64;

  localparam int DATA_AW = $clog2(DATA_DEPTH);
  localparam int DU_W    = DATA_AW + 1;
  localparam int DU_X    = DU_W + 1;
  localparam int REC_AW  = $clog2(RECORD_DEPTH);
  localparam int RU_W    = REC_AW + 1;

  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = CMDQ_AW + 1;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_REC_FULL  = 2'd1,
    ST_DATA_FULL = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    CMD_STATUS = 1'b0,
    CMD_POP    = 1'b1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    status_t             status;
    logic [LEN_W-1:0]    length;
    logic [REC_AW-1:0]   rec_ptr;
  } cmd_t;

  typedef struct packed {
    logic                data_we;
    logic [DATA_AW-1:0]  data_addr;
    logic [BYTE_W-1:0]   data_val;
    logic                rec_we;
    logic [REC_AW-1:0]   rec_addr;
    logic [LEN_W-1:0]    rec_val;
  } store_wr_t;

  typedef struct packed {
    logic                valid;
    logic [LEN_W-1:0]    len;
  } pop_done_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_LEN    = 2'd1,
    BK_STREAM = 2'd2
  } back_state_t;

endpackage
`default_nettype wire

/* rtl/lfpf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpf_front
// Accepts words, admits or rejects packets, owns the write side and the
// occupancy counters, and queues status answers and pop jobs for the back.
// ----------------------------------------------------------------------------
module lfpf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         kind,
  input  logic                         first,
  input  logic [lfpf_pkg::LEN_W-1:0]   packet_length,
  input  logic [lfpf_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         q_full,
  input  lfpf_pkg::pop_done_t          pop_done,
  output logic                         busy,
  output lfpf_pkg::store_wr_t          store_wr,
  output logic                         enq,
  output lfpf_pkg::cmd_t               enq_cmd
);
  import lfpf_pkg::*;

  logic [DATA_AW-1:0] data_write_ptr, data_write_ptr_next;
  logic [DU_W-1:0]    data_used, data_used_next;
  logic [REC_AW-1:0]  length_write_ptr, length_write_ptr_next;
  logic [REC_AW-1:0]  length_read_ptr, length_read_ptr_next;
  logic [RU_W-1:0]    length_used, length_used_next;
  logic               packet_open, packet_open_next;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;
  logic               pop_wait, pop_wait_next;

  logic               accept, is_push, is_pop, new_pkt, admit, store_now, pop_empty;
  logic               too_long, no_data_room, no_rec_room;
  logic [DU_X-1:0]    used_plus_len;
  logic [LEN_W-1:0]   left_dec, plen_dec;
  status_t            push_status;

  assign busy    = pop_wait | q_full;
  assign accept  = start & ~busy;
  assign is_push = accept & (kind == KIND_PUSH);
  assign is_pop  = accept & (kind == KIND_POP);

  assign used_plus_len = DU_X'(data_used) + DU_X'(packet_length);
  assign too_long      = packet_length > LEN_W'(MAX_PACKET);
  assign no_data_room  = used_plus_len >= DU_X'(DATA_DEPTH);
  assign no_rec_room   = length_used > RU_W'(RECORD_DEPTH - 2);

  always_comb begin
    if (too_long || no_data_room) begin
      push_status = ST_DATA_FULL;
    end else if (no_rec_room) begin
      push_status = ST_REC_FULL;
    end else begin
      push_status = ST_OK;
    end
  end

  // the packet still being filled is not poppable
  assign pop_empty = (length_used == '0) || (packet_open && (length_used == RU_W'(1)));
  assign new_pkt   = is_push & ~packet_open & first;
  assign admit     = new_pkt & (push_status == ST_OK);
  assign store_now = is_push & (packet_open | (admit & (packet_length != '0)));

  assign left_dec = (bytes_left != '0) ? bytes_left - 1'b1 : '0;
  assign plen_dec = (packet_length != '0) ? packet_length - 1'b1 : '0;

  always_comb begin
    store_wr.data_we   = store_now;
    store_wr.data_addr = data_write_ptr;
    store_wr.data_val  = data_byte;
    store_wr.rec_we    = admit;
    store_wr.rec_addr  = length_write_ptr;
    store_wr.rec_val   = packet_length;
  end

  assign enq = new_pkt | is_pop;

  always_comb begin
    enq_cmd.rec_ptr = length_read_ptr;
    if (is_pop) begin
      enq_cmd.op     = pop_empty ? CMD_STATUS : CMD_POP;
      enq_cmd.status = pop_empty ? ST_EMPTY : ST_OK;
      enq_cmd.length = '0;
    end else begin
      enq_cmd.op     = CMD_STATUS;
      enq_cmd.status = push_status;
      enq_cmd.length = packet_length;
    end
  end

  always_comb begin
    data_write_ptr_next   = data_write_ptr;
    data_used_next        = data_used;
    length_write_ptr_next = length_write_ptr;
    length_read_ptr_next  = length_read_ptr;
    length_used_next      = length_used;
    packet_open_next      = packet_open;
    bytes_left_next       = bytes_left;
    pop_wait_next         = pop_wait;

    if (store_now) begin
      data_write_ptr_next = (data_write_ptr == DATA_AW'(DATA_DEPTH - 1)) ?
                            '0 : data_write_ptr + 1'b1;
    end

    if (is_push) begin
      if (packet_open) begin
        bytes_left_next  = left_dec;
        packet_open_next = (left_dec != '0);
      end else if (!first) begin
        bytes_left_next = left_dec;   // dropping a rejected packet
      end else if (admit) begin
        length_write_ptr_next = (length_write_ptr == REC_AW'(RECORD_DEPTH - 1)) ?
                                '0 : length_write_ptr + 1'b1;
        length_used_next      = length_used + 1'b1;
        data_used_next        = data_used + DU_W'(packet_length);
        bytes_left_next       = plen_dec;
        packet_open_next      = (plen_dec != '0);
      end else begin
        bytes_left_next = plen_dec;
      end
    end

    if (is_pop && !pop_empty) begin
      length_read_ptr_next = (length_read_ptr == REC_AW'(RECORD_DEPTH - 1)) ?
                             '0 : length_read_ptr + 1'b1;
      length_used_next     = length_used - 1'b1;
      pop_wait_next        = 1'b1;
    end

    if (pop_done.valid) begin
      data_used_next = data_used - DU_W'(pop_done.len);
      pop_wait_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_write_ptr   <= '0;
      data_used        <= '0;
      length_write_ptr <= '0;
      length_read_ptr  <= '0;
      length_used      <= '0;
      packet_open      <= 1'b0;
      bytes_left       <= '0;
      pop_wait         <= 1'b0;
    end else begin
      data_write_ptr   <= data_write_ptr_next;
      data_used        <= data_used_next;
      length_write_ptr <= length_write_ptr_next;
      length_read_ptr  <= length_read_ptr_next;
      length_used      <= length_used_next;
      packet_open      <= packet_open_next;
      bytes_left       <= bytes_left_next;
      pop_wait         <= pop_wait_next;
    end
  end

  a_data_used_bound: assert property (@(posedge clk) disable iff (rst)
    data_used < DU_W'(DATA_DEPTH))
    else $error("data occupancy reached the ring size");

  a_length_used_bound: assert property (@(posedge clk) disable iff (rst)
    length_used < RU_W'(RECORD_DEPTH))
    else $error("record occupancy reached the ring size");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    pop_done.valid |-> pop_wait && !accept)
    else $error("pop completion without an outstanding pop");

endmodule
`default_nettype wire

/* rtl/lfpf_cmdq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpf_cmdq
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module lfpf_cmdq (
  input  logic            clk,
  input  logic            rst,
  input  logic            enq,
  input  lfpf_pkg::cmd_t  enq_cmd,
  input  logic            deq,
  output logic            q_valid,
  output lfpf_pkg::cmd_t  q_cmd,
  output logic            q_full
);
  import lfpf_pkg::*;

  cmd_t                entry [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]  wr_ptr, rd_ptr;
  logic [CMDQ_CW-1:0]  count, count_next;

  assign q_valid = (count != '0);
  assign q_full  = (count == CMDQ_CW'(CMDQ_DEPTH));
  assign q_cmd   = entry[rd_ptr];

  always_comb begin
    case ({enq, deq})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      entry[wr_ptr] <= enq_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/lfpf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpf_back
// Holds the byte ring and the record ring, drains jobs from the queue and
// drives the result word: status answers directly, pops one byte per cycle.
// ----------------------------------------------------------------------------
module lfpf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  lfpf_pkg::store_wr_t           store_wr,
  input  logic                          q_valid,
  input  lfpf_pkg::cmd_t                q_cmd,
  output logic                          deq,
  output lfpf_pkg::pop_done_t           pop_done,
  output logic                          strobe,
  output logic [lfpf_pkg::STATUS_W-1:0] status,
  output logic                          byte_valid,
  output logic [lfpf_pkg::BYTE_W-1:0]   data_byte_out,
  output logic                          last,
  output logic [lfpf_pkg::LEN_W-1:0]    length_out
);
  import lfpf_pkg::*;

  logic [BYTE_W-1:0]  data_mem [DATA_DEPTH];
  logic [LEN_W-1:0]   rec_mem  [RECORD_DEPTH];
  logic [BYTE_W-1:0]  data_rd;
  logic [LEN_W-1:0]   rec_rd;

  back_state_t        state, state_next;
  logic [DATA_AW-1:0] data_read_ptr;
  logic [LEN_W-1:0]   left;
  logic [LEN_W-1:0]   pop_len;

  logic               out_strobe, out_byte, out_last;
  status_t            out_status;
  logic [LEN_W-1:0]   out_len;

  logic               rec_rd_en, data_rd_en;
  logic               res_valid, res_byte, res_last;
  status_t            res_status;
  logic [LEN_W-1:0]   res_len;
  logic [LEN_W-1:0]   rec_len;

  assign rec_len = (rec_rd > LEN_W'(MAX_PACKET)) ? LEN_W'(MAX_PACKET) : rec_rd;

  always_ff @(posedge clk) begin
    if (store_wr.data_we) begin
      data_mem[store_wr.data_addr] <= store_wr.data_val;
    end
    if (data_rd_en) begin
      data_rd <= data_mem[data_read_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr.rec_we) begin
      rec_mem[store_wr.rec_addr] <= store_wr.rec_val;
    end
    if (rec_rd_en) begin
      rec_rd <= rec_mem[q_cmd.rec_ptr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid && (q_cmd.op == CMD_POP)) begin
          state_next = BK_LEN;
        end
      end
      BK_LEN: begin
        state_next = (rec_len == '0) ? BK_IDLE : BK_STREAM;
      end
      BK_STREAM: begin
        if (left == LEN_W'(1)) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    deq            = 1'b0;
    rec_rd_en      = 1'b0;
    data_rd_en     = 1'b0;
    res_valid      = 1'b0;
    res_status     = ST_OK;
    res_byte       = 1'b0;
    res_last       = 1'b0;
    res_len        = '0;
    pop_done.valid = 1'b0;
    pop_done.len   = '0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          deq = 1'b1;
          if (q_cmd.op == CMD_STATUS) begin
            res_valid  = 1'b1;
            res_status = q_cmd.status;
            res_last   = 1'b1;
            res_len    = q_cmd.length;
          end else begin
            rec_rd_en = 1'b1;
          end
        end
      end
      BK_LEN: begin
        if (rec_len == '0) begin
          res_valid      = 1'b1;
          res_last       = 1'b1;
          pop_done.valid = 1'b1;
        end
      end
      BK_STREAM: begin
        data_rd_en     = 1'b1;
        res_valid      = 1'b1;
        res_byte       = 1'b1;
        res_last       = (left == LEN_W'(1));
        res_len        = pop_len;
        pop_done.valid = (left == LEN_W'(1));
        pop_done.len   = pop_len;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      data_read_ptr <= '0;
      out_strobe    <= 1'b0;
    end else begin
      state      <= state_next;
      out_strobe <= res_valid;
      if (data_rd_en) begin
        data_read_ptr <= (data_read_ptr == DATA_AW'(DATA_DEPTH - 1)) ?
                         '0 : data_read_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status <= res_status;
    out_byte   <= res_byte;
    out_last   <= res_last;
    out_len    <= res_len;
    if (state == BK_LEN) begin
      left    <= rec_len;
      pop_len <= rec_len;
    end else if (state == BK_STREAM) begin
      left <= left - 1'b1;
    end
  end

  // byte read data lines up with the result registers
  assign strobe        = out_strobe;
  assign status        = out_status;
  assign byte_valid    = out_byte;
  assign data_byte_out = out_byte ? data_rd : '0;
  assign last          = out_last;
  assign length_out    = out_len;

  a_no_job_during_stream: assert property (@(posedge clk) disable iff (rst)
    (state == BK_STREAM) |-> !q_valid)
    else $error("job queued while a pop is draining");

  a_bytes_contiguous: assert property (@(posedge clk) disable iff (rst)
    (out_strobe && out_byte && !out_last) |=> (out_strobe && out_byte))
    else $error("gap inside a popped packet");

endmodule
`default_nettype wire

/* rtl/length_framed_packet_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// length_framed_packet_fifo
// Packet FIFO over a byte ring and a ring of length records.
// ----------------------------------------------------------------------------
// A word is taken on a rising edge with start high and busy low. Push words
// go in one per cycle, back to back, while busy stays low; a packet header
// gets one status word out through the job queue and the result registers.
// A pop of a queued packet holds busy until its last byte is read: the back
// pulls the job and reads the length record, loads the byte count, then
// does one data-ring read per byte, so bytes leave one per cycle. A pop that
// finds no complete packet answers with one queue-empty word and does not
// hold busy. Results are shown for a single cycle with strobe high; the
// receiver must take every one, there is no back-pressure on the result
// side. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module length_framed_packet_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic                          first,
  input  logic [lfpf_pkg::LEN_W-1:0]    packet_length,
  input  logic [lfpf_pkg::BYTE_W-1:0]   data_byte,
  output logic                          strobe,
  output logic [lfpf_pkg::STATUS_W-1:0] status,
  output logic                          byte_valid,
  output logic [lfpf_pkg::BYTE_W-1:0]   data_byte_out,
  output logic                          last,
  output logic [lfpf_pkg::LEN_W-1:0]    length_out
);
  import lfpf_pkg::*;

  store_wr_t  store_wr;
  pop_done_t  pop_done;
  cmd_t       enq_cmd, q_cmd;
  logic       enq, deq, q_valid, q_full;

  lfpf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .kind          (kind),
    .first         (first),
    .packet_length (packet_length),
    .data_byte     (data_byte),
    .q_full        (q_full),
    .pop_done      (pop_done),
    .busy          (busy),
    .store_wr      (store_wr),
    .enq           (enq),
    .enq_cmd       (enq_cmd)
  );

  lfpf_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_cmd (enq_cmd),
    .deq     (deq),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_full  (q_full)
  );

  lfpf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .store_wr      (store_wr),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .deq           (deq),
    .pop_done      (pop_done),
    .strobe        (strobe),
    .status        (status),
    .byte_valid    (byte_valid),
    .data_byte_out (data_byte_out),
    .last          (last),
    .length_out    (length_out)
  );

endmodule
`default_nettype wire
